>>> rtl/lcdc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdc_pkg
// Shared constants and types of the LCD controller command/data port.
// ----------------------------------------------------------------------------
package lcdc_pkg;

   localparam int PAGE_COUNT   = 16;
   localparam int COLUMN_COUNT = 256;
   localparam int RAM_DEPTH    = PAGE_COUNT * COLUMN_COUNT;
   localparam int RAM_ADDR_W   = $clog2(RAM_DEPTH);

   localparam logic [5:0] CONTRAST_RESET = 6'h20;
   localparam logic [7:0] MUX_RESET      = 8'hA0;

   localparam logic OPERATION_COMMAND = 1'b0;
   localparam logic OPERATION_DATA    = 1'b1;

   // One display RAM write.
   typedef struct packed {
      logic       en;
      logic [3:0] page;
      logic [7:0] column;
      logic [7:0] data;
   } ram_wr_type;

   // One response, as delivered on the result channel.
   typedef struct packed {
      logic       redraw;
      logic       command_done;
      logic       ram_written;
      logic [3:0] write_page;
      logic [7:0] write_column;
      logic [5:0] contrast_level;
      logic [7:0] multiplex_ratio;
      logic [7:0] first_line;
      logic       remap_on;
   } result_type;

endpackage
`default_nettype wire

>>> rtl/lcdc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdc_ram
// Display RAM, one write port, with a clearing sweep after reset.
// ----------------------------------------------------------------------------
module lcdc_ram
   import lcdc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire ram_wr_type wr,
   output logic            busy
);

   logic [7:0]            mem [RAM_DEPTH];
   logic [RAM_ADDR_W-1:0] clr_addr_ff;
   logic [RAM_ADDR_W-1:0] clr_addr_in;
   logic                  busy_ff;
   logic                  busy_in;
   logic [RAM_ADDR_W-1:0] wr_addr;

   // page stays below PAGE_COUNT on a write, so the truncated concat is in range
   assign wr_addr = RAM_ADDR_W'({wr.page, wr.column});
   assign busy    = busy_ff;

   always_comb begin
      clr_addr_in = clr_addr_ff;
      busy_in     = busy_ff;
      if (busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == RAM_ADDR_W'(RAM_DEPTH - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         busy_ff     <= busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_addr_ff] <= 8'h00;
      end else if (wr.en) begin
         mem[wr_addr] <= wr.data;
      end
   end

endmodule
`default_nettype wire

>>> rtl/lcdc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdc_ctrl
// Command assembly, register updates and RAM write addressing.
// ----------------------------------------------------------------------------
module lcdc_ctrl
   import lcdc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic       operation,
   input  wire logic [7:0] data_byte,
   output result_type      result,
   output ram_wr_type      ram_wr
);

   localparam logic [7:0] OP_COL_LOW_FIRST   = 8'h00;
   localparam logic [7:0] OP_COL_LOW_LAST    = 8'h0F;
   localparam logic [7:0] OP_COL_HIGH_FIRST  = 8'h10;
   localparam logic [7:0] OP_COL_HIGH_LAST   = 8'h17;
   localparam logic [7:0] OP_START_FIRST     = 8'h40;
   localparam logic [7:0] OP_START_LAST      = 8'h43;
   localparam logic [7:0] OP_MUX_FIRST       = 8'h48;
   localparam logic [7:0] OP_MUX_LAST        = 8'h4B;
   localparam logic [7:0] OP_CONTRAST        = 8'h81;
   localparam logic [7:0] OP_REMAP_OFF       = 8'hA0;
   localparam logic [7:0] OP_REMAP_ON        = 8'hA1;
   localparam logic [7:0] OP_PAGE_FIRST      = 8'hB0;
   localparam logic [7:0] OP_PAGE_LAST       = 8'hBF;
   localparam logic [7:0] OP_CLEAR           = 8'hE2;
   localparam logic [7:0] OP_TWO_A_FIRST     = 8'h40;
   localparam logic [7:0] OP_TWO_A_LAST      = 8'h4F;
   localparam logic [7:0] OP_TWO_B_FIRST     = 8'h60;
   localparam logic [7:0] OP_TWO_B_LAST      = 8'h63;
   localparam logic [7:0] OP_TWO_C_FIRST     = 8'h88;
   localparam logic [7:0] OP_TWO_C_LAST      = 8'h8F;
   localparam logic [7:0] OP_TWO_D_FIRST     = 8'hE8;
   localparam logic [7:0] OP_TWO_D_LAST      = 8'hE9;

   logic       pending_ff,  pending_in;
   logic [7:0] held_ff,     held_in;
   logic [3:0] page_ff,     page_in;
   logic [7:0] column_ff,   column_in;
   logic [7:0] start_ff,    start_in;
   logic [5:0] contrast_ff, contrast_in;
   logic [7:0] mux_ff,      mux_in;
   logic       remap_ff,    remap_in;

   logic       two_byte;
   logic       run;
   logic [7:0] op;
   logic [7:0] arg;
   logic       redraw;

   always_comb begin
      two_byte = 1'b0;
      case (data_byte) inside
         [OP_TWO_A_FIRST:OP_TWO_A_LAST],
         [OP_TWO_B_FIRST:OP_TWO_B_LAST],
         OP_CONTRAST,
         [OP_TWO_C_FIRST:OP_TWO_C_LAST],
         [OP_TWO_D_FIRST:OP_TWO_D_LAST]: two_byte = 1'b1;
         default:                        two_byte = 1'b0;
      endcase
   end

   always_comb begin
      pending_in  = pending_ff;
      held_in     = held_ff;
      page_in     = page_ff;
      column_in   = column_ff;
      start_in    = start_ff;
      contrast_in = contrast_ff;
      mux_in      = mux_ff;
      remap_in    = remap_ff;
      run         = 1'b0;
      op          = pending_ff ? held_ff : data_byte;
      arg         = pending_ff ? data_byte : 8'h00;
      redraw      = 1'b0;

      ram_wr.en     = 1'b0;
      ram_wr.page   = page_ff;
      ram_wr.column = column_ff;
      ram_wr.data   = data_byte;

      if (operation == OPERATION_DATA) begin
         ram_wr.en = accept && (int'(page_ff) < PAGE_COUNT);
         column_in = column_ff + 8'd1;
      end else if (pending_ff) begin
         pending_in = 1'b0;
         run        = 1'b1;
      end else if (two_byte) begin
         held_in    = data_byte;
         pending_in = 1'b1;
      end else begin
         held_in = data_byte;
         run     = 1'b1;
      end

      if (run) begin
         unique case (op) inside
            [OP_COL_LOW_FIRST:OP_COL_LOW_LAST]: begin
               column_in = {column_ff[7:5], op[3:0], 1'b0};
            end
            [OP_COL_HIGH_FIRST:OP_COL_HIGH_LAST]: begin
               column_in = {op[2:0], column_ff[4:1], 1'b0};
            end
            [OP_START_FIRST:OP_START_LAST]: begin
               redraw   = (arg != start_ff);
               start_in = arg;
            end
            [OP_MUX_FIRST:OP_MUX_LAST]: begin
               mux_in = arg;
            end
            OP_CONTRAST: begin
               contrast_in = arg[5:0];
            end
            OP_REMAP_OFF, OP_REMAP_ON: begin
               remap_in = op[0];
            end
            [OP_PAGE_FIRST:OP_PAGE_LAST]: begin
               page_in = op[3:0];
            end
            OP_CLEAR: begin
               page_in     = 4'd0;
               column_in   = 8'd0;
               start_in    = 8'd0;
               contrast_in = CONTRAST_RESET;
            end
            default: begin
            end
         endcase
      end

      result.redraw          = redraw;
      result.command_done    = run;
      result.ram_written     = ram_wr.en;
      result.write_page      = ram_wr.en ? page_ff : 4'd0;
      result.write_column    = ram_wr.en ? column_ff : 8'd0;
      result.contrast_level  = contrast_in;
      result.multiplex_ratio = mux_in;
      result.first_line      = start_in;
      result.remap_on        = remap_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff  <= 1'b0;
         held_ff     <= 8'h00;
         page_ff     <= 4'd0;
         column_ff   <= 8'd0;
         start_ff    <= 8'd0;
         contrast_ff <= CONTRAST_RESET;
         mux_ff      <= MUX_RESET;
         remap_ff    <= 1'b0;
      end else if (accept) begin
         pending_ff  <= pending_in;
         held_ff     <= held_in;
         page_ff     <= page_in;
         column_ff   <= column_in;
         start_ff    <= start_in;
         contrast_ff <= contrast_in;
         mux_ff      <= mux_in;
         remap_ff    <= remap_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/lcd_controller_command_data_port.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcd_controller_command_data_port
// Host command/data byte port of a small LCD controller.
// ----------------------------------------------------------------------------
// Response: registered, valid in the cycle after its request is accepted.
// Throughput: one request per cycle; the response register frees in the same
//   cycle it is taken; only the RAM sweep or a stalled response stalls it.
// Reset: synchronous, active high. After reset the display RAM is swept to
//   zero, one entry per cycle, all 4096 entries (PAGE_COUNT x COLUMN_COUNT);
//   req_stall stays high until the sweep ends.
// ----------------------------------------------------------------------------
module lcd_controller_command_data_port
   import lcdc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,

   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_operation,
   input  wire logic [7:0] req_data_byte,

   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_redraw,
   output logic            rsp_command_done,
   output logic            rsp_ram_written,
   output logic [3:0]      rsp_write_page,
   output logic [7:0]      rsp_write_column,
   output logic [5:0]      rsp_contrast_level,
   output logic [7:0]      rsp_multiplex_ratio,
   output logic [7:0]      rsp_first_line,
   output logic            rsp_remap_on
);

   logic       accept;
   logic       ram_busy;
   result_type result;
   ram_wr_type ram_wr;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;

   // Hold requests while the RAM sweep runs or a response waits unread.
   assign req_stall = ram_busy || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   // Decode the byte, update the registers and form the RAM write.
   lcdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .operation (req_operation),
      .data_byte (req_data_byte),
      .result    (result),
      .ram_wr    (ram_wr)
   );

   // Display RAM; write-only from the host side.
   lcdc_ram u_ram (
      .clock (clock),
      .reset (reset),
      .wr    (ram_wr),
      .busy  (ram_busy)
   );

   // Advance the response register on accept, drop valid once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_redraw          = rsp_ff.redraw;
   assign rsp_command_done    = rsp_ff.command_done;
   assign rsp_ram_written     = rsp_ff.ram_written;
   assign rsp_write_page      = rsp_ff.write_page;
   assign rsp_write_column    = rsp_ff.write_column;
   assign rsp_contrast_level  = rsp_ff.contrast_level;
   assign rsp_multiplex_ratio = rsp_ff.multiplex_ratio;
   assign rsp_first_line      = rsp_ff.first_line;
   assign rsp_remap_on        = rsp_ff.remap_on;

   // No request gets through while the RAM is being cleared.
   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      ram_busy |-> !accept)
      else $error("request accepted during RAM sweep");

   // An accepted request always yields a response in the next cycle.
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted request gave no response");

   // A data byte never completes a command.
   a_write_not_cmd: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ram_written) |-> !rsp_command_done)
      else $error("RAM write flagged as command");

   // Redraw only comes with a completed command.
   a_redraw_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_redraw) |-> rsp_command_done)
      else $error("redraw without completed command");

endmodule
`default_nettype wire

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb - LCD controller command/data port testbench
// Drives host command and data requests into the port and checks every
// response against a cycle-free predictor of the command decoder, with
// random idling on both channels and one long response hold-off.
// ----------------------------------------------------------------------------
module tb
   import lcdc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   logic       clock = 1'b0;
   logic       reset = 1'b1;

   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_operation = OPERATION_COMMAND;
   logic [7:0] req_data_byte = 8'h00;

   logic       rsp_valid;
   logic       rsp_stall = 1'b1;
   logic       rsp_redraw;
   logic       rsp_command_done;
   logic       rsp_ram_written;
   logic [3:0] rsp_write_page;
   logic [7:0] rsp_write_column;
   logic [5:0] rsp_contrast_level;
   logic [7:0] rsp_multiplex_ratio;
   logic [7:0] rsp_first_line;
   logic       rsp_remap_on;

   // Predicted controller state, mirrored request by request.
   logic [7:0] last_opcode;
   logic       arg_wait;
   logic [3:0] page_ptr;
   logic [7:0] column_ptr;
   logic [7:0] start_line;
   logic [5:0] contrast;
   logic [7:0] mux_value;
   logic       seg_remap;

   result_type   expected_responses[$];
   int unsigned  mismatches = 0;
   int unsigned  req_idle_pct = 0;
   int unsigned  rsp_idle_pct = 0;
   int unsigned  requests_sent = 0;
   logic         hold_rsp = 1'b0;

   lcd_controller_command_data_port i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Opcodes that wait for an argument byte.
   function automatic bit takes_argument(input logic [7:0] opc);
      return (opc >= 8'h40 && opc <= 8'h4F) || (opc >= 8'h60 && opc <= 8'h63) ||
             (opc == 8'h81) || (opc >= 8'h88 && opc <= 8'h8F) ||
             (opc == 8'hE8) || (opc == 8'hE9);
   endfunction

   // Carry out one complete command; return 1 when the start line changed.
   function automatic bit apply_command(input logic [7:0] opc, input logic [7:0] arg);
      bit changed;
      changed = 1'b0;
      if (opc <= 8'h0F) begin
         column_ptr = {column_ptr[7:5], opc[3:0], 1'b0};
      end else if (opc <= 8'h17) begin
         column_ptr = {opc[2:0], column_ptr[4:1], 1'b0};
      end else if (opc >= 8'h40 && opc <= 8'h43) begin
         changed    = (arg != start_line);
         start_line = arg;
      end else if (opc >= 8'h48 && opc <= 8'h4B) begin
         mux_value = arg;
      end else if (opc == 8'h81) begin
         contrast = arg[5:0];
      end else if (opc == 8'hA0 || opc == 8'hA1) begin
         seg_remap = opc[0];
      end else if (opc >= 8'hB0 && opc <= 8'hBF) begin
         page_ptr = opc[3:0];
      end else if (opc == 8'hE2) begin
         page_ptr   = '0;
         column_ptr = '0;
         start_line = '0;
         contrast   = CONTRAST_RESET;
      end
      return changed;
   endfunction

   // Work out the response to one accepted request and advance the state.
   function automatic result_type predict_response(input logic opn, input logic [7:0] b);
      result_type r;
      r = '0;
      if (opn == OPERATION_DATA) begin
         // Drop the byte when the page lies beyond the RAM; the column moves on anyway.
         if (int'(page_ptr) < PAGE_COUNT) begin
            r.ram_written  = 1'b1;
            r.write_page   = page_ptr;
            r.write_column = column_ptr;
         end
         column_ptr = column_ptr + 8'd1;
      end else if (arg_wait) begin
         // The waiting opcode takes this command byte as its argument.
         arg_wait       = 1'b0;
         r.redraw       = apply_command(last_opcode, b);
         r.command_done = 1'b1;
      end else if (takes_argument(b)) begin
         last_opcode = b;
         arg_wait    = 1'b1;
      end else begin
         last_opcode    = b;
         r.redraw       = apply_command(b, 8'h00);
         r.command_done = 1'b1;
      end
      r.contrast_level  = contrast;
      r.multiplex_ratio = mux_value;
      r.first_line      = start_line;
      r.remap_on        = seg_remap;
      return r;
   endfunction

   // Offer one request, idling first at the current sender rate, and hold it
   // until accepted. Return at the accepting edge so the caller can advance.
   task automatic send_request(input logic opn, input logic [7:0] b);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= opn;
      req_data_byte <= b;
      do @(posedge clock); while (req_stall);
      expected_responses.push_back(predict_response(opn, b));
      requests_sent++;
   endtask

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      end
   endtask

   // Check each taken response against the oldest prediction, then decide
   // whether to stall the next one.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_responses.size() == 0) begin
            mismatches++;
            $display("%0t: response with none expected, expected none, actual redraw=%0b done=%0b",
                     $time, rsp_redraw, rsp_command_done);
         end else begin
            want = expected_responses.pop_front();
            check_field("redraw", want.redraw, rsp_redraw);
            check_field("command_done", want.command_done, rsp_command_done);
            check_field("ram_written", want.ram_written, rsp_ram_written);
            check_field("write_page", want.write_page, rsp_write_page);
            check_field("write_column", want.write_column, rsp_write_column);
            check_field("contrast_level", want.contrast_level, rsp_contrast_level);
            check_field("multiplex_ratio", want.multiplex_ratio, rsp_multiplex_ratio);
            check_field("first_line", want.first_line, rsp_first_line);
            check_field("remap_on", want.remap_on, rsp_remap_on);
         end
      end
      rsp_stall <= hold_rsp || ($urandom_range(99) < rsp_idle_pct);
   end

   // Boundary columns, page extremes, every handled command, unhandled ones
   // of both lengths, a data byte slipped in while an argument is awaited.
   task automatic test_directed_commands();
      send_request(OPERATION_DATA,    8'h00);
      send_request(OPERATION_COMMAND, 8'h0F);
      send_request(OPERATION_COMMAND, 8'h17);
      send_request(OPERATION_DATA,    8'hFF);
      send_request(OPERATION_DATA,    8'hA5);
      send_request(OPERATION_DATA,    8'h5A);   // written at column 0, after the column wrapped
      send_request(OPERATION_COMMAND, 8'hBF);
      send_request(OPERATION_COMMAND, 8'h00);
      send_request(OPERATION_COMMAND, 8'h10);
      send_request(OPERATION_DATA,    8'h3C);
      send_request(OPERATION_COMMAND, 8'h40);
      send_request(OPERATION_COMMAND, 8'hFF);   // start line changes: redraw
      send_request(OPERATION_COMMAND, 8'h43);
      send_request(OPERATION_COMMAND, 8'hFF);   // same start line: no redraw
      send_request(OPERATION_COMMAND, 8'h4B);
      send_request(OPERATION_COMMAND, 8'h00);
      send_request(OPERATION_COMMAND, 8'h81);
      send_request(OPERATION_DATA,    8'h77);   // data while contrast awaits its byte
      send_request(OPERATION_COMMAND, 8'hFF);
      send_request(OPERATION_COMMAND, 8'hA1);
      send_request(OPERATION_COMMAND, 8'hE9);
      send_request(OPERATION_COMMAND, 8'h12);
      send_request(OPERATION_COMMAND, 8'hFE);
      send_request(OPERATION_COMMAND, 8'hE2);
      send_request(OPERATION_COMMAND, 8'hA0);
      send_request(OPERATION_COMMAND, 8'hB0);
   endtask

   // Mostly well-formed commands with random content, data bursts, and a
   // share of arbitrary bytes as noise.
   task automatic test_random_commands(input int unsigned count);
      int unsigned stop_at;
      int unsigned pick;
      logic [7:0]  opc;
      stop_at = requests_sent + count;
      while (requests_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            repeat ($urandom_range(1, 4)) send_request(OPERATION_DATA, 8'($urandom_range(255)));
         end else if (pick < 45) begin
            send_request(OPERATION_COMMAND, 8'($urandom_range(8'h17)));
         end else if (pick < 52) begin
            send_request(OPERATION_COMMAND, 8'hB0 | 8'($urandom_range(15)));
         end else if (pick < 62) begin
            send_request(OPERATION_COMMAND, 8'h40 | 8'($urandom_range(3)));
            send_request(OPERATION_COMMAND,
                         $urandom_range(1) ? start_line : 8'($urandom_range(255)));
         end else if (pick < 68) begin
            send_request(OPERATION_COMMAND, 8'h48 | 8'($urandom_range(3)));
            send_request(OPERATION_COMMAND, 8'($urandom_range(255)));
         end else if (pick < 75) begin
            send_request(OPERATION_COMMAND, 8'h81);
            send_request(OPERATION_COMMAND, 8'($urandom_range(255)));
         end else if (pick < 78) begin
            send_request(OPERATION_COMMAND, 8'hA0 | 8'($urandom_range(1)));
         end else if (pick < 80) begin
            send_request(OPERATION_COMMAND, 8'hE2);
         end else if (pick < 86) begin
            // Two-byte command with data interleaved before its argument.
            case ($urandom_range(5))
               0:       opc = 8'h40 | 8'($urandom_range(3));
               1:       opc = 8'h44 | 8'($urandom_range(11));
               2:       opc = 8'h60 | 8'($urandom_range(3));
               3:       opc = 8'h88 | 8'($urandom_range(7));
               4:       opc = 8'hE8 | 8'($urandom_range(1));
               default: opc = 8'h81;
            endcase
            send_request(OPERATION_COMMAND, opc);
            repeat ($urandom_range(1, 3)) send_request(OPERATION_DATA, 8'($urandom_range(255)));
            send_request(OPERATION_COMMAND, 8'($urandom_range(255)));
         end else if (pick < 93) begin
            opc = 8'($urandom_range(255));
            send_request(OPERATION_COMMAND, opc);
            if (takes_argument(opc))
               send_request(OPERATION_COMMAND, 8'($urandom_range(255)));
         end else begin
            send_request(1'($urandom_range(1)), 8'($urandom_range(255)));
         end
      end
   endtask

   // Hold the response channel for a long stretch while requests keep
   // coming, so the port fills and stalls its input.
   task automatic test_response_hold_off();
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (80) @(posedge clock);
            hold_rsp <= 1'b0;
         end
         test_random_commands(40);
      join
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Mirror the reset state.
      last_opcode = '0;
      arg_wait    = 1'b0;
      page_ptr    = '0;
      column_ptr  = '0;
      start_line  = '0;
      contrast    = CONTRAST_RESET;
      mux_value   = MUX_RESET;
      seg_remap   = 1'b0;

      // The first request waits out the RAM clearing sweep on req_stall.
      test_directed_commands();

      req_idle_pct = 29;
      rsp_idle_pct = 60;
      test_random_commands(240);

      req_idle_pct = 60;
      rsp_idle_pct = 29;
      test_random_commands(240);

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_response_hold_off();
      test_random_commands(160);

      req_valid <= 1'b0;
      while (expected_responses.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Bound the run: clearing sweep plus every request at its slowest pace,
   // many times over.
   initial begin
      #2ms;
      $display("Regression FAIL");
      $finish;
   end

endmodule
